// ----- src/bmm_pkg.sv -----
// ----------------------------------------------------------------------------
// bmm_pkg: shared types for the bipartite check / maximum matching block
// Request and result payloads and the sequencer state codes.
// ----------------------------------------------------------------------------
package bmm_pkg;

	// One request: an edge, or an empty closing item
	typedef struct packed {
		logic [8:0] vertex_a;
		logic [8:0] vertex_b;
		logic       has_edge;
		logic       last_item;
	} bmm_req_t;

	// One result per graph
	typedef struct packed {
		logic       is_bipartite;
		logic [7:0] matching_size;
	} bmm_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LD_A,    // store edge a->b
		ST_LD_RB,   // fetch head of b
		ST_LD_B,    // store edge b->a
		ST_CS,      // colouring: next seed vertex
		ST_CS2,
		ST_CQ,      // pop work queue
		ST_CU,
		ST_CU2,
		ST_CK,      // walk adjacency list
		ST_CV,
		ST_CV2,
		ST_MS,      // matching: next root
		ST_MS2,
		ST_ZAP,     // stamp clear on round wrap
		ST_AI,
		ST_AI2,
		ST_AT,      // stack top
		ST_AP,      // pop
		ST_AP2,
		ST_AV,
		ST_AV2,
		ST_APUSH,
		ST_AA,      // apply augmenting path
		ST_AA2,
		ST_AA3,
		ST_CLR      // clearing pass
	} bmm_state_t;

	localparam logic [1:0] COL_NONE = 2'd0;
	localparam logic [1:0] COL_ONE  = 2'd1;
	localparam logic [1:0] COL_SUM  = 2'd3;

endpackage

// ----- src/bmm_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmm_ctrl: graph stores and walk sequencer
// Holds the adjacency lists, colours, partners, stamps, queue and stack in
// single-port-write memories and steps colouring and augmenting search.
// ----------------------------------------------------------------------------
module bmm_ctrl #(
	parameter int MAX_VERTICES = 256,
	parameter int MAX_EDGES    = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  bmm_pkg::bmm_req_t                 req,
	input  logic [$clog2(MAX_VERTICES+1)-1:0] n,
	output logic                              busy,
	output logic                              done,
	output bmm_pkg::bmm_rsp_t                 rsp
);

	localparam int VW  = $clog2(MAX_VERTICES + 1);
	localparam int DW  = $clog2(MAX_VERTICES + 2);
	localparam int CAP = 2 * MAX_EDGES;
	localparam int EW  = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int CW  = $clog2(CAP + 1);
	localparam int NV  = MAX_VERTICES + 1;
	localparam logic [CW-1:0] NONE  = {CW{1'b1}};
	localparam logic [VW-1:0] VLAST = VW'(MAX_VERTICES);

	// memories
	logic [CW-1:0] head_m  [NV];
	logic [1:0]    color_m [NV];
	logic [VW-1:0] match_m [NV];
	logic [8:0]    stamp_m [NV];
	logic [VW-1:0] queue_m [NV];
	logic [VW-1:0] svert_m [NV];
	logic [CW-1:0] scur_m  [NV];
	logic [VW-1:0] etgt_m  [CAP];
	logic [CW-1:0] enext_m [CAP];

	logic          head_we, color_we, match_we, stamp_we, queue_we, svert_we, scur_we, ent_we;
	logic [VW-1:0] head_wa, color_wa, match_wa, stamp_wa, queue_wa, svert_wa, scur_wa;
	logic [VW-1:0] head_ra, color_ra, match_ra, stamp_ra, queue_ra, svert_ra, scur_ra;
	logic [EW-1:0] ent_wa, ent_ra;
	logic [CW-1:0] head_wd, scur_wd, enext_wd;
	logic [1:0]    color_wd;
	logic [VW-1:0] match_wd, queue_wd, svert_wd, etgt_wd;
	logic [8:0]    stamp_wd;

	logic [CW-1:0] head_rd_q, scur_rd_q, enext_rd_q;
	logic [1:0]    color_rd_q;
	logic [VW-1:0] match_rd_q, queue_rd_q, svert_rd_q, etgt_rd_q;
	logic [8:0]    stamp_rd_q;

	always_ff @(posedge clk) begin
		if (head_we)  head_m[head_wa]   <= head_wd;
		if (color_we) color_m[color_wa] <= color_wd;
		if (match_we) match_m[match_wa] <= match_wd;
		if (stamp_we) stamp_m[stamp_wa] <= stamp_wd;
		if (queue_we) queue_m[queue_wa] <= queue_wd;
		if (svert_we) svert_m[svert_wa] <= svert_wd;
		if (scur_we)  scur_m[scur_wa]   <= scur_wd;
		if (ent_we) begin
			etgt_m[ent_wa]  <= etgt_wd;
			enext_m[ent_wa] <= enext_wd;
		end
		head_rd_q  <= head_m[head_ra];
		color_rd_q <= color_m[color_ra];
		match_rd_q <= match_m[match_ra];
		stamp_rd_q <= stamp_m[stamp_ra];
		queue_rd_q <= queue_m[queue_ra];
		svert_rd_q <= svert_m[svert_ra];
		scur_rd_q  <= scur_m[scur_ra];
		etgt_rd_q  <= etgt_m[ent_ra];
		enext_rd_q <= enext_m[ent_ra];
	end

	// sequencer registers
	bmm_pkg::bmm_state_t state_q, state_d;
	logic [VW-1:0] a_q, a_d, b_q, b_d, v_q, v_d, w_q, w_d, sv_q, sv_d, idx_q, idx_d;
	logic          last_q, last_d, clr_stamp_q, clr_stamp_d;
	logic [CW-1:0] cnt_q, cnt_d, k_q, k_d, nk_q, nk_d, cur_q, cur_d;
	logic [DW-1:0] s_q, s_d, wr_q, wr_d, rd_q, rd_d, depth_q, depth_d, i_q, i_d;
	logic [1:0]    ucol_q, ucol_d;
	logic [8:0]    round_q, round_d, round_inc;
	logic [7:0]    size_q, size_d;
	logic          edge_ok;
	logic [VW-1:0] s_v, top_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmm_pkg::ST_CLR;
			idx_q       <= '0;
			clr_stamp_q <= 1'b1;
			cnt_q       <= '0;
			round_q     <= '0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			clr_stamp_q <= clr_stamp_d;
			cnt_q       <= cnt_d;
			round_q     <= round_d;
		end
	end

	always_ff @(posedge clk) begin
		a_q <= a_d;  b_q <= b_d;  v_q <= v_d;  w_q <= w_d;  sv_q <= sv_d;
		last_q <= last_d;  k_q <= k_d;  nk_q <= nk_d;  cur_q <= cur_d;
		s_q <= s_d;  wr_q <= wr_d;  rd_q <= rd_d;  depth_q <= depth_d;  i_q <= i_d;
		ucol_q <= ucol_d;  size_q <= size_d;
	end

	assign edge_ok = req.has_edge
		&& (req.vertex_a != 9'd0) && (32'(req.vertex_a) <= MAX_VERTICES)
		&& (req.vertex_b != 9'd0) && (32'(req.vertex_b) <= MAX_VERTICES)
		&& (32'(cnt_q) + 32'd2 <= CAP);
	assign s_v       = s_q[VW-1:0];
	assign top_v     = VW'(depth_q - DW'(1));
	assign round_inc = round_q + 9'd1;
	assign busy      = (state_q != bmm_pkg::ST_IDLE);

	// next state, memory requests and result
	always_comb begin
		state_d = state_q;
		a_d = a_q;  b_d = b_q;  v_d = v_q;  w_d = w_q;  sv_d = sv_q;  idx_d = idx_q;
		last_d = last_q;  clr_stamp_d = clr_stamp_q;
		cnt_d = cnt_q;  k_d = k_q;  nk_d = nk_q;  cur_d = cur_q;
		s_d = s_q;  wr_d = wr_q;  rd_d = rd_q;  depth_d = depth_q;  i_d = i_q;
		ucol_d = ucol_q;  round_d = round_q;  size_d = size_q;
		head_we = 1'b0;  color_we = 1'b0;  match_we = 1'b0;  stamp_we = 1'b0;
		queue_we = 1'b0; svert_we = 1'b0;  scur_we = 1'b0;   ent_we = 1'b0;
		head_wa = '0;  color_wa = '0;  match_wa = '0;  stamp_wa = '0;
		queue_wa = '0; svert_wa = '0;  scur_wa = top_v;  ent_wa = cnt_q[EW-1:0];
		head_ra = '0;  color_ra = '0;  match_ra = '0;  stamp_ra = '0;
		queue_ra = '0; svert_ra = '0;  scur_ra = '0;   ent_ra = k_q[EW-1:0];
		head_wd = cnt_q;  scur_wd = nk_q;  enext_wd = head_rd_q;  color_wd = bmm_pkg::COL_NONE;
		match_wd = '0;  queue_wd = '0;  svert_wd = '0;  etgt_wd = b_q;  stamp_wd = '0;
		done = 1'b0;
		rsp.is_bipartite  = 1'b1;
		rsp.matching_size = size_q;

		unique case (state_q)
			bmm_pkg::ST_IDLE: begin
				if (start) begin
					a_d    = VW'(req.vertex_a);
					b_d    = VW'(req.vertex_b);
					last_d = req.last_item;
					head_ra = VW'(req.vertex_a);
					s_d = DW'(1);
					if (edge_ok) state_d = bmm_pkg::ST_LD_A;
					else if (req.last_item) state_d = bmm_pkg::ST_CS;
				end
			end
			bmm_pkg::ST_LD_A: begin
				ent_we = 1'b1;  etgt_wd = b_q;
				head_we = 1'b1; head_wa = a_q;
				cnt_d = cnt_q + CW'(1);
				state_d = bmm_pkg::ST_LD_RB;
			end
			bmm_pkg::ST_LD_RB: begin
				head_ra = b_q;
				state_d = bmm_pkg::ST_LD_B;
			end
			bmm_pkg::ST_LD_B: begin
				ent_we = 1'b1;  etgt_wd = a_q;
				head_we = 1'b1; head_wa = b_q;
				cnt_d = cnt_q + CW'(1);
				state_d = last_q ? bmm_pkg::ST_CS : bmm_pkg::ST_IDLE;
			end
			// two-colouring by breadth-first search
			bmm_pkg::ST_CS: begin
				color_ra = s_v;
				if (s_q > DW'(n)) begin
					s_d = DW'(1);
					size_d = '0;
					state_d = bmm_pkg::ST_MS;
				end else state_d = bmm_pkg::ST_CS2;
			end
			bmm_pkg::ST_CS2: begin
				if (color_rd_q != bmm_pkg::COL_NONE) begin
					s_d = s_q + DW'(1);
					state_d = bmm_pkg::ST_CS;
				end else begin
					color_we = 1'b1; color_wa = s_v; color_wd = bmm_pkg::COL_ONE;
					queue_we = 1'b1; queue_wa = '0;  queue_wd = s_v;
					wr_d = DW'(1);
					rd_d = '0;
					state_d = bmm_pkg::ST_CQ;
				end
			end
			bmm_pkg::ST_CQ: begin
				queue_ra = rd_q[VW-1:0];
				if (rd_q < wr_q) begin
					rd_d = rd_q + DW'(1);
					state_d = bmm_pkg::ST_CU;
				end else begin
					s_d = s_q + DW'(1);
					state_d = bmm_pkg::ST_CS;
				end
			end
			bmm_pkg::ST_CU: begin
				head_ra  = queue_rd_q;
				color_ra = queue_rd_q;
				state_d  = bmm_pkg::ST_CU2;
			end
			bmm_pkg::ST_CU2: begin
				k_d = head_rd_q;
				ucol_d = color_rd_q;
				state_d = bmm_pkg::ST_CK;
			end
			bmm_pkg::ST_CK: begin
				ent_ra = k_q[EW-1:0];
				state_d = (k_q < cnt_q) ? bmm_pkg::ST_CV : bmm_pkg::ST_CQ;
			end
			bmm_pkg::ST_CV: begin
				v_d = etgt_rd_q;
				k_d = enext_rd_q;
				color_ra = etgt_rd_q;
				if (etgt_rd_q == '0 || etgt_rd_q > n) state_d = bmm_pkg::ST_CK;
				else state_d = bmm_pkg::ST_CV2;
			end
			bmm_pkg::ST_CV2: begin
				if (color_rd_q != bmm_pkg::COL_NONE) begin
					if (color_rd_q == ucol_q) begin
						// clash: not two-colourable
						done = 1'b1;
						rsp.is_bipartite  = 1'b0;
						rsp.matching_size = '0;
						cnt_d = '0;
						idx_d = '0;
						state_d = bmm_pkg::ST_CLR;
					end else state_d = bmm_pkg::ST_CK;
				end else begin
					color_we = 1'b1; color_wa = v_q; color_wd = bmm_pkg::COL_SUM - ucol_q;
					if (32'(wr_q) <= MAX_VERTICES) begin
						queue_we = 1'b1; queue_wa = wr_q[VW-1:0]; queue_wd = v_q;
						wr_d = wr_q + DW'(1);
					end
					state_d = bmm_pkg::ST_CK;
				end
			end
			// augmenting-path search from each colour-one vertex
			bmm_pkg::ST_MS: begin
				color_ra = s_v;
				if (s_q > DW'(n)) begin
					done = 1'b1;
					cnt_d = '0;
					idx_d = '0;
					state_d = bmm_pkg::ST_CLR;
				end else state_d = bmm_pkg::ST_MS2;
			end
			bmm_pkg::ST_MS2: begin
				if (color_rd_q != bmm_pkg::COL_ONE) begin
					s_d = s_q + DW'(1);
					state_d = bmm_pkg::ST_MS;
				end else if (round_inc == '0) begin
					round_d = 9'd1;
					idx_d = '0;
					state_d = bmm_pkg::ST_ZAP;
				end else begin
					round_d = round_inc;
					state_d = bmm_pkg::ST_AI;
				end
			end
			bmm_pkg::ST_ZAP: begin
				stamp_we = 1'b1; stamp_wa = idx_q; stamp_wd = '0;
				idx_d = idx_q + VW'(1);
				if (idx_q == VLAST) state_d = bmm_pkg::ST_AI;
			end
			bmm_pkg::ST_AI: begin
				head_ra = s_v;
				state_d = bmm_pkg::ST_AI2;
			end
			bmm_pkg::ST_AI2: begin
				svert_we = 1'b1; svert_wa = '0; svert_wd = s_v;
				scur_we  = 1'b1; scur_wa  = '0; scur_wd  = head_rd_q;
				cur_d = head_rd_q;
				depth_d = DW'(1);
				state_d = bmm_pkg::ST_AT;
			end
			bmm_pkg::ST_AT: begin
				ent_ra  = cur_q[EW-1:0];
				scur_ra = VW'(depth_q - DW'(2));
				if (cur_q < cnt_q) state_d = bmm_pkg::ST_AV;
				else if (depth_q == DW'(1)) begin
					s_d = s_q + DW'(1);
					state_d = bmm_pkg::ST_MS;
				end else begin
					depth_d = depth_q - DW'(1);
					state_d = bmm_pkg::ST_AP;
				end
			end
			bmm_pkg::ST_AP: begin
				ent_ra = scur_rd_q[EW-1:0];
				if (scur_rd_q < cnt_q) state_d = bmm_pkg::ST_AP2;
				else begin
					cur_d = NONE;
					scur_we = 1'b1; scur_wd = NONE;
					state_d = bmm_pkg::ST_AT;
				end
			end
			bmm_pkg::ST_AP2: begin
				cur_d = enext_rd_q;
				scur_we = 1'b1; scur_wd = enext_rd_q;
				state_d = bmm_pkg::ST_AT;
			end
			bmm_pkg::ST_AV: begin
				v_d  = etgt_rd_q;
				nk_d = enext_rd_q;
				stamp_ra = etgt_rd_q;
				match_ra = etgt_rd_q;
				if (etgt_rd_q == '0 || etgt_rd_q > n) begin
					cur_d = enext_rd_q;
					scur_we = 1'b1; scur_wd = enext_rd_q;
					state_d = bmm_pkg::ST_AT;
				end else state_d = bmm_pkg::ST_AV2;
			end
			bmm_pkg::ST_AV2: begin
				if (stamp_rd_q == round_q) begin
					cur_d = nk_q;
					scur_we = 1'b1; scur_wd = nk_q;
					state_d = bmm_pkg::ST_AT;
				end else begin
					stamp_we = 1'b1; stamp_wa = v_q; stamp_wd = round_q;
					head_ra = match_rd_q;
					if (match_rd_q == '0) begin
						i_d = '0;
						state_d = bmm_pkg::ST_AA;
					end else if (32'(depth_q) < MAX_VERTICES + 1) begin
						w_d = match_rd_q;
						state_d = bmm_pkg::ST_APUSH;
					end else begin
						cur_d = nk_q;
						scur_we = 1'b1; scur_wd = nk_q;
						state_d = bmm_pkg::ST_AT;
					end
				end
			end
			bmm_pkg::ST_APUSH: begin
				svert_we = 1'b1; svert_wa = depth_q[VW-1:0]; svert_wd = w_q;
				scur_we  = 1'b1; scur_wa  = depth_q[VW-1:0]; scur_wd  = head_rd_q;
				cur_d = head_rd_q;
				depth_d = depth_q + DW'(1);
				state_d = bmm_pkg::ST_AT;
			end
			// flip partners along the stack
			bmm_pkg::ST_AA: begin
				scur_ra  = i_q[VW-1:0];
				svert_ra = i_q[VW-1:0];
				if (i_q == depth_q) begin
					size_d = size_q + 8'd1;
					s_d = s_q + DW'(1);
					state_d = bmm_pkg::ST_MS;
				end else state_d = bmm_pkg::ST_AA2;
			end
			bmm_pkg::ST_AA2: begin
				ent_ra = scur_rd_q[EW-1:0];
				sv_d = svert_rd_q;
				if (scur_rd_q < cnt_q) state_d = bmm_pkg::ST_AA3;
				else begin
					i_d = i_q + DW'(1);
					state_d = bmm_pkg::ST_AA;
				end
			end
			bmm_pkg::ST_AA3: begin
				if (32'(etgt_rd_q) <= MAX_VERTICES) begin
					match_we = 1'b1; match_wa = etgt_rd_q; match_wd = sv_q;
				end
				i_d = i_q + DW'(1);
				state_d = bmm_pkg::ST_AA;
			end
			// clearing pass, one vertex a cycle
			bmm_pkg::ST_CLR: begin
				head_we  = 1'b1; head_wa  = idx_q; head_wd  = NONE;
				color_we = 1'b1; color_wa = idx_q; color_wd = bmm_pkg::COL_NONE;
				match_we = 1'b1; match_wa = idx_q; match_wd = '0;
				stamp_we = clr_stamp_q; stamp_wa = idx_q; stamp_wd = '0;
				idx_d = idx_q + VW'(1);
				if (idx_q == VLAST) begin
					clr_stamp_d = 1'b0;
					state_d = bmm_pkg::ST_IDLE;
				end
			end
			default: state_d = bmm_pkg::ST_IDLE;
		endcase
	end

endmodule

// ----- src/bipartite_check_max_matching.sv -----
// ----------------------------------------------------------------------------
// bipartite_check_max_matching: two-colouring check and maximum matching
// An edge request steps through LD_A, LD_RB and LD_B to store it both ways;
// a request with no edge that is not last is taken in idle. The last request
// runs the graph walk, whose length depends on the graph, then strobes one
// result for one cycle (the receiver cannot stall) and then clears all
// MAX_VERTICES+1 entries; after reset this clearing runs before busy falls.
// ----------------------------------------------------------------------------
module bipartite_check_max_matching #(
	parameter int MAX_VERTICES = 256,
	parameter int MAX_EDGES    = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bmm_pkg::bmm_req_t request,
	input  logic              cfg_we,
	input  logic [8:0]        cfg_wdata,
	output logic              result_valid,
	output bmm_pkg::bmm_rsp_t result
);

	localparam int VW = $clog2(MAX_VERTICES + 1);

	logic [8:0]        vertex_count_q;
	logic [VW-1:0]     n_clamped;
	logic              done;
	logic              result_valid_q;
	bmm_pkg::bmm_rsp_t rsp;
	bmm_pkg::bmm_rsp_t result_q;

	// vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vertex_count_q <= 9'd256;
		else if (cfg_we) vertex_count_q <= cfg_wdata;
	end

	// count above the store size is treated as the store size
	assign n_clamped = (32'(vertex_count_q) > MAX_VERTICES) ? VW'(MAX_VERTICES)
	                                                        : VW'(vertex_count_q);

	bmm_ctrl #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES   (MAX_EDGES)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (request),
		.n     (n_clamped),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid_q <= 1'b0;
		else result_valid_q <= done;
	end

	always_ff @(posedge clk) begin
		if (done) result_q <= rsp;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- test/tb_bipartite_check_max_matching.sv -----
// ----------------------------------------------------------------------------
// tb_bipartite_check_max_matching: self-checking bench for the matching block
// Drives edge requests and closing requests, predicts the two-colouring and
// maximum matching per graph, and checks each strobed result in order.
// ----------------------------------------------------------------------------
module tb_bipartite_check_max_matching;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NV = 256;
	localparam int NE = 4096;
	localparam int CAP = 2 * NE;
	localparam int NONE = -1;

	// Scoreboard: graph predictor plus queue of expected results
	class matching_scoreboard;
		int vcount;
		int head[NV + 1];
		int tgt[CAP];
		int nxt[CAP];
		int used;
		int colour[NV + 1];
		int partner[NV + 1];
		int stamp[NV + 1];
		int round_no;
		bmm_pkg::bmm_rsp_t pending[$];
		int errors;

		function new();
			vcount = 256;
			round_no = 0;
			errors = 0;
			foreach (stamp[i]) stamp[i] = 0;
			wipe();
		endfunction

		function void wipe();
			for (int i = 0; i <= NV; i++) begin
				head[i] = NONE;
				colour[i] = 0;
				partner[i] = 0;
			end
			used = 0;
		endfunction

		function void link(int f, int t);
			tgt[used] = t;
			nxt[used] = head[f];
			head[f] = used;
			used++;
		endfunction

		function int valid_entry(int k);
			return (k >= 0 && k < used);
		endfunction

		function bit colour_graph(int n);
			int q[$];
			int u, k, v;
			for (int s = 1; s <= n; s++) begin
				if (colour[s] != 0) continue;
				colour[s] = 1;
				q.delete();
				q.push_back(s);
				while (q.size() > 0) begin
					u = q.pop_front();
					k = head[u];
					while (valid_entry(k)) begin
						v = tgt[k];
						k = nxt[k];
						if (v < 1 || v > n) continue;
						if (colour[v] != 0) begin
							if (colour[v] == colour[u]) return 0;
							continue;
						end
						colour[v] = 3 - colour[u];
						q.push_back(v);
					end
				end
			end
			return 1;
		endfunction

		function int augment(int root, int n);
			int sv[NV + 2];
			int sc[NV + 2];
			int depth, k, v, c;
			depth = 1;
			sv[0] = root;
			sc[0] = head[root];
			while (depth > 0) begin
				k = sc[depth - 1];
				if (!valid_entry(k)) begin
					depth--;
					if (depth > 0) sc[depth - 1] =
						valid_entry(sc[depth - 1]) ? nxt[sc[depth - 1]] : NONE;
					continue;
				end
				v = tgt[k];
				if (v < 1 || v > n || stamp[v] == round_no) begin
					sc[depth - 1] = nxt[k];
					continue;
				end
				stamp[v] = round_no;
				if (partner[v] == 0) begin
					for (int i = 0; i < depth; i++) begin
						c = sc[i];
						if (valid_entry(c) && tgt[c] <= NV) partner[tgt[c]] = sv[i];
					end
					return 1;
				end
				if (depth < NV + 1) begin
					sv[depth] = partner[v];
					sc[depth] = head[partner[v]];
					depth++;
				end else
					sc[depth - 1] = nxt[k];
			end
			return 0;
		endfunction

		// Note an accepted request; queue a result on a last request
		function void note_request(bmm_pkg::bmm_req_t r);
			int a, b, n, total;
			bit bip;
			bmm_pkg::bmm_rsp_t e;
			a = r.vertex_a;
			b = r.vertex_b;
			if (r.has_edge && a >= 1 && a <= NV && b >= 1 && b <= NV && used + 2 <= CAP) begin
				link(a, b);
				link(b, a);
			end
			if (!r.last_item) return;
			n = (vcount > NV) ? NV : vcount;
			total = 0;
			bip = colour_graph(n);
			if (bip) begin
				for (int s = 1; s <= n; s++) begin
					if (colour[s] != 1) continue;
					round_no = (round_no + 1) & 9'h1ff;
					if (round_no == 0) begin
						foreach (stamp[i]) stamp[i] = 0;
						round_no = 1;
					end
					total += augment(s, n);
				end
			end
			e.is_bipartite = bip;
			e.matching_size = bip ? total[7:0] : 8'd0;
			pending.push_back(e);
			wipe();
		endfunction

		function void check_result(bmm_pkg::bmm_rsp_t got);
			bmm_pkg::bmm_rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d/%0d",
					$time, got.is_bipartite, got.matching_size);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.is_bipartite !== e.is_bipartite) begin
				$display("%0t: is_bipartite mismatch, expected %0d, actual %0d",
					$time, e.is_bipartite, got.is_bipartite);
				errors++;
			end
			if (got.matching_size !== e.matching_size) begin
				$display("%0t: matching_size mismatch, expected %0d, actual %0d",
					$time, e.matching_size, got.matching_size);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	bmm_pkg::bmm_req_t request;
	logic cfg_we;
	logic [8:0] cfg_wdata;
	logic result_valid;
	bmm_pkg::bmm_rsp_t result;

	matching_scoreboard sb;
	int send_gap_pct;

	bipartite_check_max_matching DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.result_valid(result_valid), .result(result)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	initial begin
		#40ms;
		$display("tb_bipartite_check_max_matching: errors");
		$finish;
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check_result(result);
	end

	// Request monitor
	always @(posedge clk) begin
		if (arst_n && start && !busy) sb.note_request(request);
	end

	// Drive one request, idling at random first, hold until accepted;
	// start stays high afterwards until the next request or a wait drops it
	task automatic send(input int a, input int b, input bit he, input bit last);
		while ($urandom_range(99) < send_gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request.vertex_a <= a[8:0];
		request.vertex_b <= b[8:0];
		request.has_edge <= he;
		request.last_item <= last;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and wait until every result is in and the block is idle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0 || busy) @(posedge clk);
	endtask

	// Wait for all results, let the clearing pass finish, then write
	task automatic set_vertices(input int n);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= n[8:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.vcount = n;
	endtask

	// Random graph with a hidden two-colouring unless noise is wanted
	task automatic random_graph(input int n, input int edges, input bit noisy);
		int a, b;
		for (int i = 0; i < edges; i++) begin
			a = $urandom_range(n, 1);
			b = $urandom_range(n, 1);
			if (!noisy && (a % 2) == (b % 2)) b = (b < n) ? b + 1 : ((b > 1) ? b - 1 : b);
			if ($urandom_range(30) == 0) a = $urandom_range(511);
			send(a, b, 1'b1, 1'b0);
		end
		if ($urandom_range(1)) send($urandom_range(511), $urandom_range(511), 1'b0, 1'b1);
		else send($urandom_range(n, 1), $urandom_range(n, 1), 1'b1, 1'b1);
	endtask

	initial begin
		int n, count;
		sb = new();
		arst_n = 0;
		start = 0;
		request = '0;
		cfg_we = 0;
		cfg_wdata = '0;
		send_gap_pct = 15;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// Directed cases at the reset count of 256
		send(0, 0, 1'b0, 1'b1);
		send(1, 256, 1'b1, 1'b0);
		send(511, 3, 1'b1, 1'b0);
		send(0, 5, 1'b1, 1'b1);
		send(7, 7, 1'b1, 1'b1);
		send(1, 2, 1'b1, 1'b0);
		send(2, 3, 1'b1, 1'b0);
		send(3, 1, 1'b1, 1'b1);
		set_vertices(4);
		send(1, 2, 1'b1, 1'b0);
		send(3, 4, 1'b1, 1'b0);
		send(2, 3, 1'b1, 1'b0);
		send(1, 200, 1'b1, 1'b0);
		send(200, 300, 1'b1, 1'b1);
		set_vertices(1);
		send(1, 1, 1'b1, 1'b1);
		set_vertices(0);
		send(1, 2, 1'b1, 1'b1);
		set_vertices(511);
		send(255, 256, 1'b1, 1'b0);
		send(256, 1, 1'b1, 1'b1);
		set_vertices(256);
		send(170, 85, 1'b1, 1'b1);

		// Random graphs in three idling phases
		count = 0;
		for (int g = 0; count < 1330; g++) begin
			if (g == 40) send_gap_pct = 61;
			if (g == 80) send_gap_pct = 0;
			if (g % 12 == 11) begin
				case ($urandom_range(3))
					0: n = 1;
					1: n = 256;
					2: n = $urandom_range(16, 2);
					default: n = $urandom_range(511, 257);
				endcase
				set_vertices(n);
			end
			n = (sb.vcount > NV) ? NV : ((sb.vcount < 1) ? 1 : sb.vcount);
			n = $urandom_range(n, 1);
			if (n > 24 && $urandom_range(9) != 0) n = $urandom_range(24, 1);
			random_graph(n, $urandom_range(20), $urandom_range(4) == 0);
			count += 11;
			if (g == 20) drain();
		end
		// Final pass near the full count with many edges
		set_vertices(256);
		random_graph(256, 400, 1'b0);

		drain();
		repeat (NV + 40) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_bipartite_check_max_matching: clean");
		else
			$display("tb_bipartite_check_max_matching: errors");
		$finish;
	end
endmodule
